// File: rtl/lcnd_pkg.sv
package lcnd_pkg;

   localparam int MAX_BEAMS_DEFAULT = 512;
   localparam int QUEUE_DEPTH       = 2;

   localparam int RANGE_W     = 16;
   localparam int SECTOR_W    = 10;
   localparam int CENTER_W    = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int TRIG_W      = 16;
   localparam int PROD_W      = 33;
   localparam int FRAC_W      = 15;
   localparam int ITEM_FLAGS  = 4;

   localparam logic [RANGE_W-1:0] HOLD_RESET = 16'd10000;

   // Angle step and reduction constants in Q32, unit in Q30.
   localparam longint unsigned STEP_Q32 =
      ((64'd6912195 << 32) + 64'd500000000) / 64'd1000000000;
   localparam longint unsigned TWO_PI_Q32  = 64'd26986075409;
   localparam longint unsigned PI_Q32      = 64'd13493037705;
   localparam longint unsigned HALF_PI_Q32 = 64'd6746518852;
   localparam longint          ONE_Q30     = 64'sd1073741824;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SECTOR_LENGTH,
      REG_CENTER_INDEX,
      REG_NEAR_LIMIT,
      REG_FAR_LIMIT,
      REG_SKIP_CENTER,
      REG_HOLD_ABOVE,
      REG_ACCEPT_BELOW
   } csr_reg_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector_length;
      logic [CENTER_W-1:0] center_index;
      logic [RANGE_W-1:0]  near_side_limit_mm;
      logic [RANGE_W-1:0]  far_side_limit_mm;
      logic                skip_center;
      logic [RANGE_W-1:0]  hold_above_mm;
      logic [RANGE_W-1:0]  accept_below_mm;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sector_length:      10'd455,
      center_index:       9'd227,
      near_side_limit_mm: 16'd150,
      far_side_limit_mm:  16'd370,
      skip_center:        1'b1,
      hold_above_mm:      HOLD_RESET,
      accept_below_mm:    16'd5000
   };

   function automatic int cnt_width(input int beams);
      return $clog2(beams);
   endfunction

   function automatic int idx_width(input int beams);
      int c;
      c = $clog2(beams);
      return (c > CENTER_W) ? c : CENTER_W;
   endfunction

   function automatic int item_width(input int beams);
      return RANGE_W + ITEM_FLAGS + cnt_width(beams) + idx_width(beams);
   endfunction

   function automatic longint clamp_unit(input longint v);
      if (v < 0) return 0;
      if (v > ONE_Q30) return ONE_Q30;
      return v;
   endfunction

   function automatic logic [TRIG_W-1:0] q30_to_q15(input longint v, input logic neg);
      longint q;
      q = (v + 64'sd16384) >>> 15;
      if (q > 64'sd32767) q = 64'sd32767;
      if (neg) q = -q;
      return q[TRIG_W-1:0];
   endfunction

   // One entry of the sine and cosine table, {sine, cosine} in Q1.15, for a beam
   // that lies d steps away from the centre beam. Evaluated at elaboration only.
   function automatic logic [2*TRIG_W-1:0] trig_entry(input int unsigned d);
      longint unsigned t;
      logic            sneg;
      logic            cneg;
      longint          x;
      longint          x2;
      longint          acc;
      logic [TRIG_W-1:0] s;
      logic [TRIG_W-1:0] c;
      t    = (64'(d) * STEP_Q32) % TWO_PI_Q32;
      sneg = 1'b0;
      cneg = 1'b0;
      if (t >= PI_Q32) begin
         t    = t - PI_Q32;
         sneg = 1'b1;
         cneg = 1'b1;
      end
      if (t > HALF_PI_Q32) begin
         t    = PI_Q32 - t;
         cneg = !cneg;
      end
      x  = longint'(t >> 2);
      x2 = (x * x) >>> 30;

      acc = ONE_Q30;
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 110);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 72);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 42);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 20);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 6);
      s   = q30_to_q15(clamp_unit((x * acc) >>> 30), sneg);

      acc = ONE_Q30;
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 132);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 90);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 56);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 30);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 12);
      acc = clamp_unit(ONE_Q30 - ((x2 * acc) >>> 30) / 2);
      c   = q30_to_q15(acc, cneg);

      return {s, c};
   endfunction

endpackage

// File: rtl/lidar_corridor_nearest_distance_unit.sv
// Corridor nearest-distance unit. Beams of a lidar sector are pushed one per
// clock as range samples; the unit sustains one item per clock cycle for as
// long as the result queue has room. A front stage numbers each beam and works
// out its offset from the centre beam, a two-entry queue decouples it from a
// three-stage back end (store and sine/cosine table read, projection
// multiplies, minimum search), and the result of a scan reaches the rsp ports
// through the back end registers and the result queue. The beam store needs no
// clearing pass after reset: a fill mark makes never-written entries read as
// zero, so the unit accepts items from the first cycle after reset.
module lidar_corridor_nearest_distance_unit import lcnd_pkg::*; #(
   parameter int MAX_BEAMS = MAX_BEAMS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [RANGE_W-1:0]     req_range_mm,
   input  logic                   req_last_of_scan,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [RANGE_W-1:0]     rsp_nearest_mm,
   output logic                   rsp_found,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ITEM_W = item_width(MAX_BEAMS);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic              mid_push;
   logic              mid_pop;
   logic              mid_empty;
   logic [ITEM_W-1:0] front_item;
   logic [ITEM_W-1:0] mid_item;
   logic              back_push;
   logic              back_full;
   logic [RANGE_W-1:0] back_nearest;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_SECTOR_LENGTH: cfg_in.sector_length      = csr_wdata[SECTOR_W-1:0];
            REG_CENTER_INDEX:  cfg_in.center_index       = csr_wdata[CENTER_W-1:0];
            REG_NEAR_LIMIT:    cfg_in.near_side_limit_mm = csr_wdata[RANGE_W-1:0];
            REG_FAR_LIMIT:     cfg_in.far_side_limit_mm  = csr_wdata[RANGE_W-1:0];
            REG_SKIP_CENTER:   cfg_in.skip_center        = csr_wdata[0];
            REG_HOLD_ABOVE:    cfg_in.hold_above_mm      = csr_wdata[RANGE_W-1:0];
            REG_ACCEPT_BELOW:  cfg_in.accept_below_mm    = csr_wdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcnd_front #(
      .MAX_BEAMS(MAX_BEAMS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_range_mm     (req_range_mm),
      .req_last_of_scan (req_last_of_scan),
      .queue_full       (req_full),
      .queue_push       (mid_push),
      .queue_item       (front_item)
   );

   lcnd_fifo #(
      .WIDTH(ITEM_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .full    (req_full),
      .wr_data (front_item),
      .pop     (mid_pop),
      .empty   (mid_empty),
      .rd_data (mid_item)
   );

   lcnd_back #(
      .MAX_BEAMS(MAX_BEAMS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .queue_empty    (mid_empty),
      .queue_item     (mid_item),
      .queue_pop      (mid_pop),
      .rsp_full       (back_full),
      .rsp_push       (back_push),
      .rsp_nearest_mm (back_nearest)
   );

   lcnd_fifo #(
      .WIDTH(RANGE_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .full    (back_full),
      .wr_data (back_nearest),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_nearest_mm)
   );

   // The accept limit must only be changed while the unit is idle (the block does
   // not enforce this), so the flag can be derived on the way out of the queue.
   assign rsp_found = (rsp_nearest_mm != '0) && (rsp_nearest_mm < cfg_ff.accept_below_mm);

endmodule

// File: rtl/lcnd_fifo.sv
module lcnd_fifo import lcnd_pkg::*; #(
   parameter int WIDTH = RANGE_W,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == COUNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/lcnd_front.sv
module lcnd_front import lcnd_pkg::*; #(
   parameter int MAX_BEAMS = MAX_BEAMS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cfg_type                            cfg,
   input  logic                               req_push,
   input  logic [RANGE_W-1:0]                 req_range_mm,
   input  logic                               req_last_of_scan,
   input  logic                               queue_full,
   output logic                               queue_push,
   output logic [item_width(MAX_BEAMS)-1:0]   queue_item
);

   localparam int CNT_W  = cnt_width(MAX_BEAMS);
   localparam int IDX_W  = idx_width(MAX_BEAMS);
   localparam int BEAM_W = $clog2(MAX_BEAMS + 1);
   localparam int LEN_W  = (BEAM_W > SECTOR_W) ? BEAM_W : SECTOR_W;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [IDX_W-1:0] beam_idx;
   logic [IDX_W-1:0] centre;
   logic [IDX_W-1:0] beam_offset;
   logic [LEN_W-1:0] len_raw;
   logic [LEN_W-1:0] len_eff;
   logic             last;
   logic             use_far;
   logic             skip;
   logic             first;

   assign queue_push = req_push && !queue_full;

   always_comb begin
      beam_idx    = IDX_W'(cnt_ff);
      centre      = IDX_W'(cfg.center_index);
      beam_offset = (beam_idx >= centre) ? beam_idx - centre : centre - beam_idx;
      use_far     = beam_idx > centre;
      skip        = cfg.skip_center && (beam_idx == centre);
      first       = (cnt_ff == '0);

      // A length of zero, or one beyond the store, runs over the whole store.
      len_raw = LEN_W'(cfg.sector_length);
      if (len_raw == '0 || len_raw > LEN_W'(MAX_BEAMS)) begin
         len_eff = LEN_W'(MAX_BEAMS);
      end else begin
         len_eff = len_raw;
      end
      last = req_last_of_scan || (LEN_W'(cnt_ff) + LEN_W'(1) >= len_eff);

      cnt_in = cnt_ff;
      if (queue_push) begin
         cnt_in = last ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   assign queue_item = {req_range_mm, last, first, skip, use_far, cnt_ff, beam_offset};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/lcnd_back.sv
module lcnd_back import lcnd_pkg::*; #(
   parameter int MAX_BEAMS = MAX_BEAMS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cfg_type                            cfg,
   input  logic                               queue_empty,
   input  logic [item_width(MAX_BEAMS)-1:0]   queue_item,
   output logic                               queue_pop,
   input  logic                               rsp_full,
   output logic                               rsp_push,
   output logic [RANGE_W-1:0]                 rsp_nearest_mm
);

   localparam int CNT_W     = cnt_width(MAX_BEAMS);
   localparam int IDX_W     = idx_width(MAX_BEAMS);
   localparam int FILL_W    = $clog2(MAX_BEAMS + 1);
   localparam int ROM_DEPTH = 1 << IDX_W;

   // Sine and cosine of each beam offset, {sine, cosine} in Q1.15.
   logic [2*TRIG_W-1:0] trig_rom [ROM_DEPTH];

   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_trig
      assign trig_rom[g] = trig_entry(g);
   end

   logic [RANGE_W-1:0] beam_store_ff [MAX_BEAMS];

   logic [RANGE_W-1:0] h_range;
   logic               h_last;
   logic               h_first;
   logic               h_skip;
   logic               h_far;
   logic [CNT_W-1:0]   h_idx;
   logic [IDX_W-1:0]   h_dist;

   logic               advance;

   // Read stage: the popped item with its store entry and table entry.
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [RANGE_W-1:0]  s1_range_ff;
   logic                s1_last_ff;
   logic                s1_first_ff;
   logic                s1_skip_ff;
   logic                s1_far_ff;
   logic [CNT_W-1:0]    s1_idx_ff;
   logic [RANGE_W-1:0]  store_rd_ff;
   logic                stored_ok_ff;
   logic [2*TRIG_W-1:0] trig_rd_ff;

   // Projection stage: both products of the cleaned range.
   logic                     s2_valid_ff;
   logic                     s2_valid_in;
   logic                     s2_last_ff;
   logic                     s2_first_ff;
   logic                     s2_skip_ff;
   logic                     s2_far_ff;
   logic signed [PROD_W-1:0] s2_lat_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;

   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic [RANGE_W-1:0] prev_ff;
   logic [RANGE_W-1:0] prev_in;
   logic [RANGE_W-1:0] min_ff;
   logic [RANGE_W-1:0] min_in;

   logic [RANGE_W-1:0]       beam_v;
   logic signed [RANGE_W:0]  beam_s;
   logic signed [TRIG_W-1:0] sin_q;
   logic signed [TRIG_W-1:0] cos_q;
   logic signed [PROD_W-1:0] lat_in;
   logic signed [PROD_W-1:0] prod_in;

   logic [RANGE_W-1:0]       limit;
   logic signed [PROD_W-1:0] limit_q;
   logic [PROD_W-1:0]        round_sum;
   logic [RANGE_W-1:0]       fwd;
   logic [RANGE_W-1:0]       base;
   logic                     take;
   logic [RANGE_W-1:0]       new_min;

   assign {h_range, h_last, h_first, h_skip, h_far, h_idx, h_dist} = queue_item;

   // The whole back end moves together; it waits only when a scan result
   // has nowhere to go.
   assign advance   = !(s2_valid_ff && s2_last_ff && rsp_full);
   assign queue_pop = advance && !queue_empty;

   // Cleaning of the range against the store. Entries beyond the fill mark
   // have never been written since reset and read as zero.
   always_comb begin
      if (s1_first_ff) begin
         beam_v = s1_range_ff;
      end else if (s1_range_ff > cfg.hold_above_mm) begin
         beam_v = prev_ff;
      end else if (s1_range_ff != '0 && s1_range_ff < cfg.accept_below_mm) begin
         beam_v = s1_range_ff;
      end else begin
         beam_v = stored_ok_ff ? store_rd_ff : '0;
      end
      beam_s  = signed'({1'b0, beam_v});
      sin_q   = signed'(trig_rd_ff[2*TRIG_W-1:TRIG_W]);
      cos_q   = signed'(trig_rd_ff[TRIG_W-1:0]);
      lat_in  = beam_s * sin_q;
      prod_in = beam_s * cos_q;
   end

   always_comb begin
      limit     = s2_far_ff ? cfg.far_side_limit_mm : cfg.near_side_limit_mm;
      limit_q   = signed'({2'b00, limit, {FRAC_W{1'b0}}});
      round_sum = unsigned'(s2_prod_ff) + PROD_W'(1 << (FRAC_W - 1));
      fwd       = round_sum[FRAC_W +: RANGE_W];
      base      = s2_first_ff ? cfg.hold_above_mm : min_ff;
      // A beam behind the sensor has a non-positive product and never counts.
      take      = !s2_skip_ff && (s2_lat_ff < limit_q)
                  && !s2_prod_ff[PROD_W-1] && (s2_prod_ff != '0)
                  && (fwd != '0) && (fwd < base);
      new_min   = take ? fwd : base;
   end

   assign rsp_push       = advance && s2_valid_ff && s2_last_ff;
   assign rsp_nearest_mm = new_min;

   always_comb begin
      s1_valid_in = advance ? !queue_empty : s1_valid_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
      fill_in     = fill_ff;
      prev_in     = prev_ff;
      min_in      = min_ff;
      if (advance && s1_valid_ff) begin
         prev_in = beam_v;
         if (FILL_W'(s1_idx_ff) >= fill_ff) begin
            fill_in = FILL_W'(s1_idx_ff) + FILL_W'(1);
         end
      end
      if (advance && s2_valid_ff) begin
         min_in = new_min;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fill_ff     <= '0;
         prev_ff     <= '0;
         min_ff      <= HOLD_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         fill_ff     <= fill_in;
         prev_ff     <= prev_in;
         min_ff      <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_range_ff  <= h_range;
         s1_last_ff   <= h_last;
         s1_first_ff  <= h_first;
         s1_skip_ff   <= h_skip;
         s1_far_ff    <= h_far;
         s1_idx_ff    <= h_idx;
         store_rd_ff  <= beam_store_ff[h_idx];
         stored_ok_ff <= FILL_W'(h_idx) < fill_ff;
         trig_rd_ff   <= trig_rom[h_dist];
         s2_last_ff   <= s1_last_ff;
         s2_first_ff  <= s1_first_ff;
         s2_skip_ff   <= s1_skip_ff;
         s2_far_ff    <= s1_far_ff;
         s2_lat_ff    <= lat_in;
         s2_prod_ff   <= prod_in;
      end
   end

   // Consecutive items never share a store entry other than beam zero, whose
   // stored value is not used, so the write-back needs no bypass.
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         beam_store_ff[s1_idx_ff] <= beam_v;
      end
   end

endmodule

// File: verif/lidar_corridor_nearest_distance_unit_tb.sv
`timescale 1ns / 100ps

module lidar_corridor_nearest_distance_unit_tb;
   import lcnd_pkg::*;

   localparam int          BEAM_SLOTS    = 512;
   localparam int          RANDOM_ITEMS  = 1700;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          DIR_ROWS      = 25;
   localparam int          STALL_CYCLES  = 300;
   localparam int          QUIET_ITEMS   = 200;

   // Angle step and reduction constants in Q32, unit in Q30.
   localparam longint unsigned ANGLE_STEP   =
      ((64'd6912195 << 32) + 64'd500000000) / 64'd1000000000;
   localparam longint unsigned FULL_TURN    = 64'd26986075409;
   localparam longint unsigned HALF_TURN    = 64'd13493037705;
   localparam longint unsigned QUARTER_TURN = 64'd6746518852;
   localparam longint          UNIT         = 64'sd1073741824;

   typedef struct packed {
      logic [RANGE_W-1:0] nearest_mm;
      logic               found;
   } scan_result_type;

   typedef struct packed {
      logic [1:0]         setting;
      logic [RANGE_W-1:0] range_mm;
      logic               last;
      logic               fixed;
      logic [RANGE_W-1:0] nearest_mm;
      logic               found;
   } beam_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic [RANGE_W-1:0]     req_range_mm;
   logic                   req_last_of_scan;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [RANGE_W-1:0]     rsp_nearest_mm;
   logic                   rsp_found;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predictor state: configuration copy and per-beam store.
   cfg_type            cfg_model;
   logic [RANGE_W-1:0] beam_mem [BEAM_SLOTS];
   int unsigned        beam_idx;
   int unsigned        prev_value;
   int unsigned        run_min;

   scan_result_type pending_scans [$];
   int              error_count;
   bit              tx_idling;
   bit              rsp_idling;
   int              pop_hold_cycles;

   lidar_corridor_nearest_distance_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_range_mm     (req_range_mm),
      .req_last_of_scan (req_last_of_scan),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_nearest_mm   (rsp_nearest_mm),
      .rsp_found        (rsp_found),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint unit_clip(input longint v);
      if (v < 0) return 0;
      if (v > UNIT) return UNIT;
      return v;
   endfunction

   function automatic logic signed [15:0] to_q15(input longint v, input bit neg);
      longint q;
      q = (v + 64'sd16384) >>> 15;
      if (q > 64'sd32767) q = 64'sd32767;
      if (neg) q = -q;
      return q[15:0];
   endfunction

   // Sine and cosine of d angle steps. The Taylor denominators are the
   // products (2m)(2m+1) for sine and (2m-1)(2m) for cosine.
   function automatic void beam_trig(input int unsigned d, output logic signed [15:0] s,
                                     output logic signed [15:0] c);
      longint unsigned t;
      bit              s_neg;
      bit              c_neg;
      longint          x;
      longint          x2;
      longint          acc;
      int              m;
      t = 64'(d);
      t = (t * ANGLE_STEP) % FULL_TURN;
      s_neg = 1'b0;
      c_neg = 1'b0;
      if (t >= HALF_TURN) begin
         t = t - HALF_TURN;
         s_neg = 1'b1;
         c_neg = 1'b1;
      end
      if (t > QUARTER_TURN) begin
         t = HALF_TURN - t;
         c_neg = !c_neg;
      end
      x  = longint'(t >> 2);
      x2 = (x * x) >>> 30;
      acc = UNIT;
      for (m = 5; m >= 1; m--)
         acc = unit_clip(UNIT - ((x2 * acc) >>> 30) / longint'(2 * m * (2 * m + 1)));
      s = to_q15(unit_clip((x * acc) >>> 30), s_neg);
      acc = UNIT;
      for (m = 6; m >= 1; m--)
         acc = unit_clip(UNIT - ((x2 * acc) >>> 30) / longint'((2 * m - 1) * 2 * m));
      c = to_q15(acc, c_neg);
   endfunction

   function automatic int unsigned effective_length(input cfg_type c);
      if (c.sector_length == 0 || c.sector_length > BEAM_SLOTS) return BEAM_SLOTS;
      return 32'(c.sector_length);
   endfunction

   // Advances the predictor by one beam; returns 1 when the beam closes a scan.
   function automatic bit track_beam(input logic [RANGE_W-1:0] r, input logic lst,
                                     output scan_result_type res);
      int unsigned        i;
      int unsigned        v;
      int unsigned        d;
      int unsigned        lim;
      int unsigned        fwd;
      logic signed [15:0] s;
      logic signed [15:0] c;
      longint             lateral;
      longint             prod;
      i = beam_idx;
      if (i == 0) run_min = 32'(cfg_model.hold_above_mm);
      v = 32'(beam_mem[i]);
      if (i == 0) v = 32'(r);
      else if (r > cfg_model.hold_above_mm) v = prev_value;
      else if (r > 0 && r < cfg_model.accept_below_mm) v = 32'(r);
      beam_mem[i] = v[RANGE_W-1:0];
      prev_value = v;
      if (!(cfg_model.skip_center && i == cfg_model.center_index)) begin
         d = (i >= cfg_model.center_index) ? i - cfg_model.center_index
                                           : cfg_model.center_index - i;
         lim = 32'((i > cfg_model.center_index) ? cfg_model.far_side_limit_mm
                                                : cfg_model.near_side_limit_mm);
         beam_trig(d, s, c);
         lateral = longint'(v) * s;
         prod    = longint'(v) * c;
         if (lateral < (longint'(lim) << 15) && prod > 0) begin
            fwd = int'((prod + 64'sd16384) >>> 15);
            if (fwd != 0 && fwd < run_min) run_min = fwd;
         end
      end
      res = '0;
      if (!lst && i + 1 < effective_length(cfg_model)) begin
         beam_idx = i + 1;
         return 1'b0;
      end
      beam_idx = 0;
      res.nearest_mm = run_min[RANGE_W-1:0];
      res.found = (run_min > 0 && run_min < cfg_model.accept_below_mm);
      return 1'b1;
   endfunction

   function automatic logic [RANGE_W-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return RANGE_W'($urandom_range(0, 65535));
         default: return RANGE_W'($urandom_range(0, 600));
      endcase
   endfunction

   function automatic cfg_type random_setting();
      cfg_type     c;
      int unsigned n;
      case ($urandom_range(0, 11))
         0:       c.sector_length = 10'd1;
         1:       c.sector_length = 10'd512;
         2:       c.sector_length = 10'd0;
         3:       c.sector_length = 10'd1023;
         default: c.sector_length = 10'($urandom_range(2, 24));
      endcase
      n = effective_length(c);
      if ($urandom_range(0, 3) == 0) c.center_index = 9'($urandom_range(0, 511));
      else c.center_index = 9'($urandom_range(0, n - 1));
      c.near_side_limit_mm = pick_limit();
      c.far_side_limit_mm  = pick_limit();
      c.skip_center        = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0:       c.hold_above_mm = '0;
         1:       c.hold_above_mm = '1;
         2:       c.hold_above_mm = RANGE_W'($urandom_range(0, 65535));
         default: c.hold_above_mm = RANGE_W'($urandom_range(3000, 20000));
      endcase
      case ($urandom_range(0, 5))
         0:       c.accept_below_mm = '0;
         1:       c.accept_below_mm = '1;
         2:       c.accept_below_mm = RANGE_W'($urandom_range(0, 65535));
         default: c.accept_below_mm = RANGE_W'($urandom_range(1000, 12000));
      endcase
      return c;
   endfunction

   // Readings are steered to the thresholds of the hold and accept rules.
   function automatic logic [RANGE_W-1:0] pick_range(input cfg_type c);
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return RANGE_W'($urandom_range(0, 65535));
         3:       return c.hold_above_mm + 1'b1;
         4:       return c.hold_above_mm;
         5:       return c.accept_below_mm - 1'b1;
         6:       return c.accept_below_mm;
         7:       return RANGE_W'(1);
         default: return RANGE_W'($urandom_range(1, 8000));
      endcase
   endfunction

   task automatic push_beam(input logic [RANGE_W-1:0] r, input logic lst, input bit fixed,
                            input scan_result_type fixed_res);
      scan_result_type res;
      req_push         <= 1'b1;
      req_range_mm     <= r;
      req_last_of_scan <= lst;
      do @(posedge clock); while (req_full);
      if (track_beam(r, lst, res)) pending_scans.push_back(fixed ? fixed_res : res);
   endtask

   task automatic maybe_gap();
      if (tx_idling && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Holds the sender until every scan result has come and the pipeline is empty.
   task automatic drain();
      req_push <= 1'b0;
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_config(input cfg_type c);
      write_reg(REG_SECTOR_LENGTH, CSR_DATA_W'(c.sector_length));
      write_reg(REG_CENTER_INDEX,  CSR_DATA_W'(c.center_index));
      write_reg(REG_NEAR_LIMIT,    c.near_side_limit_mm);
      write_reg(REG_FAR_LIMIT,     c.far_side_limit_mm);
      write_reg(REG_SKIP_CENTER,   CSR_DATA_W'(c.skip_center));
      write_reg(REG_HOLD_ABOVE,    c.hold_above_mm);
      write_reg(REG_ACCEPT_BELOW,  c.accept_below_mm);
      csr_we <= 1'b0;
      cfg_model = c;
   endtask

   always @(posedge clock) begin : check_results
      scan_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_scans.size() == 0) begin
            $error("unexpected result: nearest_mm %0d, found %0d", rsp_nearest_mm, rsp_found);
            error_count++;
         end else begin
            want = pending_scans.pop_front();
            if (rsp_nearest_mm !== want.nearest_mm) begin
               $error("nearest_mm: expected %0d, actual %0d", want.nearest_mm, rsp_nearest_mm);
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               error_count++;
            end
         end
      end
   end

   initial begin : result_sink
      int n;
      rsp_pop = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (pop_hold_cycles != 0) begin
            n = pop_hold_cycles;
            pop_hold_cycles = 0;
         end else if (rsp_idling && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 15);
         end else begin
            n = 0;
         end
         if (n != 0) begin
            rsp_pop <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_pop <= 1'b1;
      end
   end

   initial begin : watchdog
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      beam_row_type dir_rows [DIR_ROWS];
      cfg_type      dir_cfg [4];
      cfg_type      c;
      beam_row_type row;
      logic [1:0]   setting_now;
      int           sent;
      int           phase;
      int           target;
      int           n;
      int unsigned  leff;
      int unsigned  beams;
      bit           quiet_end;
      logic         lst;

      clock            = 1'b0;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_range_mm     = '0;
      req_last_of_scan = 1'b0;
      csr_we           = 1'b0;
      csr_index        = REG_SECTOR_LENGTH;
      csr_wdata        = '0;
      error_count      = 0;
      pop_hold_cycles  = 0;
      tx_idling        = 1'b1;
      rsp_idling       = 1'b1;
      cfg_model        = CFG_RESET;
      for (int k = 0; k < BEAM_SLOTS; k++) beam_mem[k] = '0;
      beam_idx   = 0;
      prev_value = 0;
      run_min    = 32'(HOLD_RESET);

      dir_cfg[0] = CFG_RESET;
      dir_cfg[1] = '{sector_length: 10'd1, center_index: 9'd0, near_side_limit_mm: 16'd150,
                     far_side_limit_mm: 16'd370, skip_center: 1'b0,
                     hold_above_mm: 16'd10000, accept_below_mm: 16'd5000};
      dir_cfg[2] = '{sector_length: 10'd8, center_index: 9'd3, near_side_limit_mm: 16'hFFFF,
                     far_side_limit_mm: 16'hFFFF, skip_center: 1'b1,
                     hold_above_mm: 16'hFFFF, accept_below_mm: 16'hFFFF};
      dir_cfg[3] = '{sector_length: 10'd0, center_index: 9'd511, near_side_limit_mm: 16'd0,
                     far_side_limit_mm: 16'd0, skip_center: 1'b0,
                     hold_above_mm: 16'd0, accept_below_mm: 16'd0};

      // Reset settings: an empty beam and a far beam outside the corridor, then a scan cut short.
      dir_rows[0]  = '{2'd0, 16'd0,     1'b1, 1'b1, 16'd10000, 1'b0};
      dir_rows[1]  = '{2'd0, 16'd65535, 1'b1, 1'b1, 16'd10000, 1'b0};
      dir_rows[2]  = '{2'd0, 16'd1234,  1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[3]  = '{2'd0, 16'd40000, 1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[4]  = '{2'd0, 16'd0,     1'b1, 1'b0, 16'd0,     1'b0};
      // One-beam scans on the centre beam: the forward distance is the reading.
      dir_rows[5]  = '{2'd1, 16'd1000,  1'b0, 1'b1, 16'd1000,  1'b1};
      dir_rows[6]  = '{2'd1, 16'd1,     1'b0, 1'b1, 16'd1,     1'b1};
      dir_rows[7]  = '{2'd1, 16'd4999,  1'b0, 1'b1, 16'd4999,  1'b1};
      dir_rows[8]  = '{2'd1, 16'd5000,  1'b1, 1'b1, 16'd5000,  1'b0};
      dir_rows[9]  = '{2'd1, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0};
      // Eight-beam scan with the centre beam skipped, then a scan cut short.
      dir_rows[10] = '{2'd2, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[11] = '{2'd2, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[12] = '{2'd2, 16'd30000, 1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[13] = '{2'd2, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[14] = '{2'd2, 16'd12,    1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[15] = '{2'd2, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[16] = '{2'd2, 16'd65534, 1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[17] = '{2'd2, 16'd200,   1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[18] = '{2'd2, 16'd777,   1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[19] = '{2'd2, 16'd0,     1'b1, 1'b0, 16'd0,     1'b0};
      // Zero length acts as the full store; every non-zero reading after the first beam copies.
      dir_rows[20] = '{2'd3, 16'd500,   1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[21] = '{2'd3, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[22] = '{2'd3, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[23] = '{2'd3, 16'd7,     1'b0, 1'b0, 16'd0,     1'b0};
      dir_rows[24] = '{2'd3, 16'd1,     1'b1, 1'b0, 16'd0,     1'b0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      setting_now = 2'd0;
      for (int k = 0; k < DIR_ROWS; k++) begin
         row = dir_rows[k];
         if (row.setting != setting_now) begin
            drain();
            write_config(dir_cfg[row.setting]);
            setting_now = row.setting;
         end
         push_beam(row.range_mm, row.last, row.fixed, {row.nearest_mm, row.found});
         maybe_gap();
      end

      sent = 0;
      for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
         quiet_end = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
         c = random_setting();
         if (phase == 2) c.sector_length = 10'd1;
         drain();
         write_config(c);
         tx_idling  = !quiet_end && ($urandom_range(0, 3) != 0);
         rsp_idling = !quiet_end && ($urandom_range(0, 3) != 0);
         target     = quiet_end ? QUIET_ITEMS : $urandom_range(100, 160);
         // The busy phases stop exactly where the quiet closing stretch begins.
         if (!quiet_end && target > RANDOM_ITEMS - QUIET_ITEMS - sent)
            target = RANDOM_ITEMS - QUIET_ITEMS - sent;
         // Every beam closes a scan here, so a long receiver stall fills the block.
         if (phase == 2) begin
            tx_idling       = 1'b0;
            pop_hold_cycles = STALL_CYCLES;
         end
         leff = effective_length(c);
         n = 0;
         while (n < target) begin
            if (leff <= 32)
               beams = ($urandom_range(0, 4) == 0) ? $urandom_range(1, leff) : leff;
            else
               beams = ($urandom_range(0, 5) == 0) ? $urandom_range(1, leff)
                                                   : $urandom_range(1, 40);
            if (beams > target - n) beams = target - n;
            for (int unsigned b = 0; b < beams; b++) begin
               if (b == beams - 1)
                  lst = (beams < leff) ? 1'b1 : 1'($urandom_range(0, 1));
               else
                  lst = ($urandom_range(0, 49) == 0);
               push_beam(pick_range(c), lst, 1'b0, '0);
               maybe_gap();
               n++;
               sent++;
            end
         end
      end

      drain();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
